@@ design/ctsd_pkg.sv @@
// ----------------------------------------------------------------------------
// ctsd_pkg: centroid triangle subdivider shared definitions
// Widths, register indexes, payload structs and inter-module bundles.
// ----------------------------------------------------------------------------
package ctsd_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int ID_WIDTH       = 32;
    localparam int MAX_DEPTH      = 3;
    localparam int DEPTH_WIDTH    = 2;
    localparam int CFG_IDX_WIDTH  = 1;
    localparam int CFG_DATA_WIDTH = ID_WIDTH;
    localparam int JOBQ_DEPTH     = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEPTH    = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FIRST_ID = 1'b1;

    localparam logic [DEPTH_WIDTH-1:0] DEPTH_RESET = 2'd1;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_TRI   = 1'b1;

    localparam logic [1:0] CHI_FIRST = 2'd0;
    localparam logic [1:0] CHI_LAST  = 2'd2;

    typedef struct packed {
        logic        [ID_WIDTH-1:0]    corner0_id;
        logic        [ID_WIDTH-1:0]    corner1_id;
        logic        [ID_WIDTH-1:0]    corner2_id;
        logic signed [COORD_WIDTH-1:0] corner0_x;
        logic signed [COORD_WIDTH-1:0] corner0_y;
        logic signed [COORD_WIDTH-1:0] corner0_z;
        logic signed [COORD_WIDTH-1:0] corner1_x;
        logic signed [COORD_WIDTH-1:0] corner1_y;
        logic signed [COORD_WIDTH-1:0] corner1_z;
        logic signed [COORD_WIDTH-1:0] corner2_x;
        logic signed [COORD_WIDTH-1:0] corner2_y;
        logic signed [COORD_WIDTH-1:0] corner2_z;
    } t_tri_in;

    typedef struct packed {
        logic                          kind;
        logic        [ID_WIDTH-1:0]    vertex_a;
        logic        [ID_WIDTH-1:0]    vertex_b;
        logic        [ID_WIDTH-1:0]    vertex_c;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic                          id_overflow;
        logic                          last;
    } t_result;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } t_xyz;

    typedef struct packed {
        logic [ID_WIDTH-1:0] id;
        t_xyz                p;
    } t_vtx;

    typedef struct packed {
        t_tri_in                corners;
        logic [DEPTH_WIDTH-1:0] depth;
    } t_job;

    typedef struct packed {
        logic                      en;
        logic [CFG_IDX_WIDTH-1:0]  idx;
        logic [CFG_DATA_WIDTH-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic       start;
        t_xyz [2:0] pts;
    } t_cen_req;

    typedef struct packed {
        logic done;
        t_xyz c;
    } t_cen_rsp;

endpackage

@@ design/ctsd_front.sv @@
// ----------------------------------------------------------------------------
// ctsd_front: input side of the subdivider
// Accepts triangles, tags each with its effective depth and queues them.
// ----------------------------------------------------------------------------
module ctsd_front #(
    parameter int MAX_DEPTH = ctsd_pkg::MAX_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  ctsd_pkg::t_tri_in i_tri,
    input  ctsd_pkg::t_cfg_wr i_cfg,
    output logic              o_job_vld,
    output ctsd_pkg::t_job    o_job,
    input  logic              i_job_pop
);

    localparam int QD = ctsd_pkg::JOBQ_DEPTH;
    localparam int QA = (QD > 1) ? $clog2(QD) : 1;
    localparam int QC = $clog2(QD + 1);

    logic [ctsd_pkg::DEPTH_WIDTH-1:0] r_depth;
    logic [ctsd_pkg::DEPTH_WIDTH-1:0] w_eff_depth;
    ctsd_pkg::t_job                   r_q [QD];
    logic [QA-1:0]                    r_wp;
    logic [QA-1:0]                    r_rp;
    logic [QC-1:0]                    r_cnt;
    logic                             w_wr;
    logic                             w_rd;

    assign o_full    = (r_cnt == QC'(QD));
    assign o_job_vld = (r_cnt != '0);
    assign o_job     = r_q[r_rp];
    assign w_wr      = i_push && !o_full;
    assign w_rd      = i_job_pop && o_job_vld;

    always_comb begin
        if (r_depth > ctsd_pkg::DEPTH_WIDTH'(MAX_DEPTH)) begin
            w_eff_depth = ctsd_pkg::DEPTH_WIDTH'(MAX_DEPTH);
        end else begin
            w_eff_depth = r_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= ctsd_pkg::DEPTH_RESET;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg.en && i_cfg.idx == ctsd_pkg::REG_DEPTH) begin
                r_depth <= i_cfg.data[ctsd_pkg::DEPTH_WIDTH-1:0];
            end
            if (w_wr) begin
                r_wp <= (r_wp == QA'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == QA'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp].corners <= i_tri;
            r_q[r_wp].depth   <= w_eff_depth;
        end
    end

endmodule

@@ design/ctsd_centroid.sv @@
// ----------------------------------------------------------------------------
// ctsd_centroid: centroid unit
// Sums three corners per axis and divides by three, truncating toward zero,
// eight quotient bits per cycle on all three axes at once.
// ----------------------------------------------------------------------------
module ctsd_centroid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctsd_pkg::t_cen_req i_req,
    output ctsd_pkg::t_cen_rsp o_rsp
);

    localparam int CW    = ctsd_pkg::COORD_WIDTH;
    localparam int SW    = CW + 2;
    localparam int NSTEP = (SW + 7) / 8;
    localparam int DW    = NSTEP * 8;
    localparam int NW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_ABS  = 4'b0010,
        C_DIV  = 4'b0100,
        C_OUT  = 4'b1000
    } t_cstate;

    t_cstate                r_state;
    logic [NW-1:0]          r_cnt;
    logic signed [SW-1:0]   r_sum [3];
    logic                   r_neg [3];
    logic [DW-1:0]          r_dvd [3];
    logic [DW-1:0]          r_quo [3];
    logic [1:0]             r_rem [3];
    logic [DW-1:0]          n_quo [3];
    logic [1:0]             n_rem [3];
    logic signed [CW-1:0]   w_crd [3][3];
    logic [CW-1:0]          w_res [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_crd[i][0] = i_req.pts[i].x;
            w_crd[i][1] = i_req.pts[i].y;
            w_crd[i][2] = i_req.pts[i].z;
        end
    end

    always_comb begin
        logic [2:0]    t;
        logic [1:0]    rem;
        logic [DW-1:0] quo;
        for (int k = 0; k < 3; k++) begin
            rem = r_rem[k];
            quo = r_quo[k];
            for (int b = 0; b < 8; b++) begin
                t = {rem, r_dvd[k][DW-1-b]};
                if (t >= 3'd3) begin
                    rem = 2'(t - 3'd3);
                    quo = {quo[DW-2:0], 1'b1};
                end else begin
                    rem = t[1:0];
                    quo = {quo[DW-2:0], 1'b0};
                end
            end
            n_rem[k] = rem;
            n_quo[k] = quo;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_res[k] = r_neg[k] ? CW'(-r_quo[k][CW-1:0]) : r_quo[k][CW-1:0];
        end
    end

    assign o_rsp.done = (r_state == C_OUT);
    assign o_rsp.c.x  = w_res[0];
    assign o_rsp.c.y  = w_res[1];
    assign o_rsp.c.z  = w_res[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_state <= C_ABS;
                    end
                end
                C_ABS: begin
                    r_cnt   <= '0;
                    r_state <= C_DIV;
                end
                C_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == NW'(NSTEP - 1)) begin
                        r_state <= C_OUT;
                    end
                end
                C_OUT: begin
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (r_state == C_IDLE && i_req.start) begin
                r_sum[k] <= SW'(w_crd[0][k]) + SW'(w_crd[1][k]) + SW'(w_crd[2][k]);
            end
            if (r_state == C_ABS) begin
                r_neg[k] <= r_sum[k][SW-1];
                r_dvd[k] <= DW'(unsigned'(r_sum[k][SW-1] ? -r_sum[k] : r_sum[k]));
                r_quo[k] <= '0;
                r_rem[k] <= '0;
            end
            if (r_state == C_DIV) begin
                r_dvd[k] <= r_dvd[k] << 8;
                r_quo[k] <= n_quo[k];
                r_rem[k] <= n_rem[k];
            end
        end
    end

endmodule

@@ design/ctsd_back.sv @@
// ----------------------------------------------------------------------------
// ctsd_back: traversal engine
// Walks the subdivision tree in pre-order with a per-level frame stack,
// hands out point ids and drives the result register.
// ----------------------------------------------------------------------------
module ctsd_back #(
    parameter int MAX_DEPTH = ctsd_pkg::MAX_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctsd_pkg::t_cfg_wr  i_cfg,
    input  logic               i_job_vld,
    input  ctsd_pkg::t_job     i_job,
    output logic               o_job_pop,
    output ctsd_pkg::t_cen_req o_cen,
    input  ctsd_pkg::t_cen_rsp i_cen,
    output logic               o_empty,
    input  logic               i_pop,
    output ctsd_pkg::t_result  o_res
);

    localparam int LW  = $clog2(MAX_DEPTH + 1);
    localparam int SPW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int IW  = ctsd_pkg::ID_WIDTH;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_NODE  = 5'b00010,
        B_WAIT  = 5'b00100,
        B_PNT   = 5'b01000,
        B_CLIMB = 5'b10000
    } t_bstate;

    typedef struct packed {
        ctsd_pkg::t_vtx [2:0] v;
        ctsd_pkg::t_vtx       c;
    } t_frame;

    t_bstate                          r_state;
    logic [LW-1:0]                    r_lvl;
    logic [ctsd_pkg::DEPTH_WIDTH-1:0] r_depth;
    logic                             r_ovf;
    logic [IW-1:0]                    r_next_id;
    ctsd_pkg::t_vtx [2:0]             r_cur;
    ctsd_pkg::t_xyz                   r_cen;
    t_frame                           r_stk [MAX_DEPTH];
    logic [1:0]                       r_chi [MAX_DEPTH];
    logic                             r_ovld;
    ctsd_pkg::t_result                r_out;

    logic           w_out_rdy;
    logic           w_leaf;
    logic           w_all_done;
    logic           w_sat;
    logic           w_emit;
    logic [SPW-1:0] w_push;
    logic [SPW-1:0] w_top;
    t_frame         w_tf;
    logic [1:0]     w_tchi;
    ctsd_pkg::t_vtx w_cvtx;

    assign w_out_rdy = !r_ovld || i_pop;
    assign w_leaf    = ctsd_pkg::DEPTH_WIDTH'(r_lvl) >= r_depth;
    assign w_sat     = (r_next_id == '1);
    assign w_emit    = ((r_state == B_NODE) && w_leaf && w_out_rdy) ||
                       ((r_state == B_PNT) && w_out_rdy);
    assign w_push    = SPW'(r_lvl);
    assign w_top     = SPW'(r_lvl - 1'b1);
    assign w_tf      = r_stk[w_top];
    assign w_tchi    = r_chi[w_top];
    assign w_cvtx.id = r_next_id;
    assign w_cvtx.p  = r_cen;

    always_comb begin
        w_all_done = 1'b1;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (i < int'(r_lvl) && r_chi[i] != ctsd_pkg::CHI_LAST) begin
                w_all_done = 1'b0;
            end
        end
    end

    assign o_job_pop = (r_state == B_IDLE) && i_job_vld;

    always_comb begin
        o_cen.start = (r_state == B_NODE) && !w_leaf;
        for (int i = 0; i < 3; i++) begin
            o_cen.pts[i] = r_cur[i].p;
        end
    end

    assign o_empty = !r_ovld;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_lvl     <= '0;
            r_ovf     <= 1'b0;
            r_next_id <= '0;
            r_ovld    <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovld <= 1'b1;
            end else if (i_pop) begin
                r_ovld <= 1'b0;
            end
            if (i_cfg.en && i_cfg.idx == ctsd_pkg::REG_FIRST_ID) begin
                r_next_id <= IW'(i_cfg.data);
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_vld) begin
                        r_lvl   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= B_NODE;
                    end
                end
                B_NODE: begin
                    if (w_leaf) begin
                        if (w_out_rdy) begin
                            r_state <= w_all_done ? B_IDLE : B_CLIMB;
                        end
                    end else begin
                        r_state <= B_WAIT;
                    end
                end
                B_WAIT: begin
                    if (i_cen.done) begin
                        r_state <= B_PNT;
                    end
                end
                B_PNT: begin
                    if (w_out_rdy) begin
                        if (w_sat) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_next_id <= r_next_id + 1'b1;
                        end
                        r_lvl   <= r_lvl + 1'b1;
                        r_state <= B_NODE;
                    end
                end
                B_CLIMB: begin
                    if (w_tchi == ctsd_pkg::CHI_LAST) begin
                        r_lvl <= r_lvl - 1'b1;
                    end else begin
                        r_state <= B_NODE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_job_vld) begin
                    r_depth      <= i_job.depth;
                    r_cur[0].id  <= i_job.corners.corner0_id;
                    r_cur[0].p.x <= i_job.corners.corner0_x;
                    r_cur[0].p.y <= i_job.corners.corner0_y;
                    r_cur[0].p.z <= i_job.corners.corner0_z;
                    r_cur[1].id  <= i_job.corners.corner1_id;
                    r_cur[1].p.x <= i_job.corners.corner1_x;
                    r_cur[1].p.y <= i_job.corners.corner1_y;
                    r_cur[1].p.z <= i_job.corners.corner1_z;
                    r_cur[2].id  <= i_job.corners.corner2_id;
                    r_cur[2].p.x <= i_job.corners.corner2_x;
                    r_cur[2].p.y <= i_job.corners.corner2_y;
                    r_cur[2].p.z <= i_job.corners.corner2_z;
                end
            end
            B_NODE: begin
                if (w_leaf && w_out_rdy) begin
                    r_out.kind        <= ctsd_pkg::KIND_TRI;
                    r_out.vertex_a    <= r_cur[0].id;
                    r_out.vertex_b    <= r_cur[1].id;
                    r_out.vertex_c    <= r_cur[2].id;
                    r_out.point_x     <= '0;
                    r_out.point_y     <= '0;
                    r_out.point_z     <= '0;
                    r_out.id_overflow <= r_ovf;
                    r_out.last        <= w_all_done;
                end
            end
            B_WAIT: begin
                if (i_cen.done) begin
                    r_cen <= i_cen.c;
                end
            end
            B_PNT: begin
                if (w_out_rdy) begin
                    r_out.kind        <= ctsd_pkg::KIND_POINT;
                    r_out.vertex_a    <= r_next_id;
                    r_out.vertex_b    <= '0;
                    r_out.vertex_c    <= '0;
                    r_out.point_x     <= r_cen.x;
                    r_out.point_y     <= r_cen.y;
                    r_out.point_z     <= r_cen.z;
                    r_out.id_overflow <= r_ovf || w_sat;
                    r_out.last        <= 1'b0;
                    r_stk[w_push].v   <= r_cur;
                    r_stk[w_push].c   <= w_cvtx;
                    r_chi[w_push]     <= ctsd_pkg::CHI_FIRST;
                    // child (a, c, b)
                    r_cur[1] <= w_cvtx;
                    r_cur[2] <= r_cur[1];
                end
            end
            B_CLIMB: begin
                if (w_tchi != ctsd_pkg::CHI_LAST) begin
                    r_chi[w_top] <= w_tchi + 1'b1;
                    r_cur[2]     <= w_tf.c;
                    if (w_tchi == ctsd_pkg::CHI_FIRST) begin
                        // child (b, d, c)
                        r_cur[0] <= w_tf.v[1];
                        r_cur[1] <= w_tf.v[2];
                    end else begin
                        // child (d, a, c)
                        r_cur[0] <= w_tf.v[2];
                        r_cur[1] <= w_tf.v[0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ design/centroid_triangle_subdivider_unit.sv @@
// ----------------------------------------------------------------------------
// centroid_triangle_subdivider_unit: recursive 1-to-3 centroid subdivider
// Splits each input triangle about its centroid down to the set depth and
// streams new points and leaf triangles in pre-order.
// ----------------------------------------------------------------------------
// Input: push a triangle (ids and Q16.16 corners) while full is low; a
//   two-entry queue holds triangles waiting for the traversal engine.
// Results: while empty is low o_res holds the oldest result; pop takes it.
//   Points and triangles of one input come out in pre-order, last marks the
//   final one. One result register; a stalled receiver stops the traversal,
//   nothing is dropped.
// Config: i_cfg_we with index 0 sets the depth (reset 1, clamped to
//   MAX_DEPTH), index 1 loads the first new point id (reset 0). The id
//   counter carries over from one triangle to the next.
// Timing: a point passes through one sum, one magnitude, five divide
//   steps of eight bits and one sign step, plus handoff; the time per
//   triangle grows with depth and is set by the shared centroid unit.
// Reset: synchronous, empties queue and result register, clears id counter.
// ----------------------------------------------------------------------------
module centroid_triangle_subdivider_unit #(
    parameter int MAX_DEPTH = ctsd_pkg::MAX_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  ctsd_pkg::t_tri_in                   i_tri,
    output logic                                empty,
    input  logic                                pop,
    output ctsd_pkg::t_result                   o_res,
    input  logic                                i_cfg_we,
    input  logic [ctsd_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [ctsd_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data
);

    ctsd_pkg::t_cfg_wr  w_cfg;
    logic               w_job_vld;
    ctsd_pkg::t_job     w_job;
    logic               w_job_pop;
    ctsd_pkg::t_cen_req w_cen_req;
    ctsd_pkg::t_cen_rsp w_cen_rsp;

    assign w_cfg.en   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    ctsd_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_tri     (i_tri),
        .i_cfg     (w_cfg),
        .o_job_vld (w_job_vld),
        .o_job     (w_job),
        .i_job_pop (w_job_pop)
    );

    ctsd_centroid u_cen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cen_req),
        .o_rsp   (w_cen_rsp)
    );

    ctsd_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_job_vld (w_job_vld),
        .i_job     (w_job),
        .o_job_pop (w_job_pop),
        .o_cen     (w_cen_req),
        .i_cen     (w_cen_rsp),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_res     (o_res)
    );

endmodule

@@ design/ctsd_checker.sv @@
// ----------------------------------------------------------------------------
// ctsd_sva: port-level checks for the subdivider
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module ctsd_sva (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input ctsd_pkg::t_result i_res
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result channel not empty after reset");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(i_res)))
        else $error("waiting result beat changed or vanished");

    a_tri_no_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && i_res.kind == ctsd_pkg::KIND_TRI) |->
        (i_res.point_x == '0 && i_res.point_y == '0 && i_res.point_z == '0))
        else $error("triangle beat carries coordinates");

    a_point_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && i_res.kind == ctsd_pkg::KIND_POINT) |->
        (i_res.vertex_b == '0 && i_res.vertex_c == '0 && !i_res.last))
        else $error("point beat has corner ids or ends a triangle");

    a_sat_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && i_res.kind == ctsd_pkg::KIND_POINT && i_res.id_overflow) |->
        (i_res.vertex_a == '1))
        else $error("overflowed point id not saturated");

endmodule

bind centroid_triangle_subdivider_unit ctsd_sva u_sva (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .i_res   (o_res)
);

@@ tb/ctsd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctsd_checker: result checker for the centroid triangle subdivider
// Watches the triangle, result and register ports and keeps its own copy of
// the depth, the id counter and the subdivision walk. It expands each
// accepted triangle into the expected pre-order stream of centroid points and
// leaf triangles, then compares every popped beat, field by field, against
// the oldest one still waiting.
// ----------------------------------------------------------------------------
module ctsd_checker
    import ctsd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    input  logic                      full,
    input  t_tri_in                   i_tri,
    input  logic                      empty,
    input  logic                      pop,
    input  t_result                   i_res,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_points,
    output int                        o_tris
);

    t_result                expected_beats[$];
    logic [DEPTH_WIDTH-1:0] depth_q;
    logic [ID_WIDTH-1:0]    next_id_q;

    t_vtx       node_v    [0:MAX_DEPTH][0:2];
    t_vtx       cen_v     [0:MAX_DEPTH];
    logic [1:0] child_idx [0:MAX_DEPTH];

    t_result held_beat;
    bit      held_valid;
    int      mismatches;
    int      stray_beats;
    int      point_count;
    int      tri_count;

    function automatic logic signed [COORD_WIDTH-1:0] coord_third(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b,
        input logic signed [COORD_WIDTH-1:0] c
    );
        longint sum;
        longint q;
        sum = longint'(a) + longint'(b) + longint'(c);
        q   = sum / 3;
        return q[COORD_WIDTH-1:0];
    endfunction

    // children of (a,b,d) about centroid c: (a,c,b), (b,d,c), (d,a,c)
    function automatic void load_child(input int p);
        case (child_idx[p])
            CHI_FIRST: begin
                node_v[p+1][0] = node_v[p][0];
                node_v[p+1][1] = cen_v[p];
                node_v[p+1][2] = node_v[p][1];
            end
            CHI_LAST: begin
                node_v[p+1][0] = node_v[p][2];
                node_v[p+1][1] = node_v[p][0];
                node_v[p+1][2] = cen_v[p];
            end
            default: begin
                node_v[p+1][0] = node_v[p][1];
                node_v[p+1][1] = node_v[p][2];
                node_v[p+1][2] = cen_v[p];
            end
        endcase
    endfunction

    // one beat held back so the final one of a triangle can be marked last
    function automatic void emit_beat(input t_result r);
        if (held_valid) expected_beats.insert(expected_beats.size(), held_beat);
        held_beat  = r;
        held_valid = 1'b1;
    endfunction

    function automatic string beat_text(input t_result r);
        return $sformatf("kind %0d a %h b %h c %h xyz %h %h %h ovf %0d last %0d",
                         r.kind, r.vertex_a, r.vertex_b, r.vertex_c,
                         r.point_x, r.point_y, r.point_z, r.id_overflow, r.last);
    endfunction

    task automatic subdivide_triangle(input t_tri_in t);
        int      lvl;
        int      eff_depth;
        bit      ovf;
        bit      fin;
        bit      climbing;
        t_vtx    cen;
        t_result beat;
        eff_depth = (int'(depth_q) > MAX_DEPTH) ? MAX_DEPTH : int'(depth_q);
        node_v[0][0] = {t.corner0_id, t.corner0_x, t.corner0_y, t.corner0_z};
        node_v[0][1] = {t.corner1_id, t.corner1_x, t.corner1_y, t.corner1_z};
        node_v[0][2] = {t.corner2_id, t.corner2_x, t.corner2_y, t.corner2_z};
        lvl        = 0;
        ovf        = 1'b0;
        fin        = 1'b0;
        held_valid = 1'b0;
        while (!fin) begin
            if (lvl >= eff_depth) begin
                beat             = '0;
                beat.kind        = KIND_TRI;
                beat.vertex_a    = node_v[lvl][0].id;
                beat.vertex_b    = node_v[lvl][1].id;
                beat.vertex_c    = node_v[lvl][2].id;
                beat.id_overflow = ovf;
                emit_beat(beat);
                tri_count++;
                climbing = 1'b1;
                while (climbing) begin
                    if (lvl == 0) begin
                        climbing = 1'b0;
                        fin      = 1'b1;
                    end else if (child_idx[lvl-1] == CHI_LAST) begin
                        lvl--;
                    end else begin
                        child_idx[lvl-1]++;
                        load_child(lvl - 1);
                        climbing = 1'b0;
                    end
                end
            end else begin
                cen.p.x = coord_third(node_v[lvl][0].p.x, node_v[lvl][1].p.x,
                                      node_v[lvl][2].p.x);
                cen.p.y = coord_third(node_v[lvl][0].p.y, node_v[lvl][1].p.y,
                                      node_v[lvl][2].p.y);
                cen.p.z = coord_third(node_v[lvl][0].p.z, node_v[lvl][1].p.z,
                                      node_v[lvl][2].p.z);
                cen.id  = next_id_q;
                if (next_id_q == '1) ovf = 1'b1;
                else next_id_q = next_id_q + 1'b1;
                beat             = '0;
                beat.kind        = KIND_POINT;
                beat.vertex_a    = cen.id;
                beat.point_x     = cen.p.x;
                beat.point_y     = cen.p.y;
                beat.point_z     = cen.p.z;
                beat.id_overflow = ovf;
                emit_beat(beat);
                point_count++;
                cen_v[lvl]     = cen;
                child_idx[lvl] = CHI_FIRST;
                load_child(lvl);
                lvl++;
            end
        end
        held_beat.last = 1'b1;
        expected_beats.insert(expected_beats.size(), held_beat);
        held_valid = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            expected_beats.delete();
            depth_q     = DEPTH_RESET;
            next_id_q   = '0;
            mismatches  = 0;
            stray_beats = 0;
            point_count = 0;
            tri_count   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEPTH:    depth_q   = i_cfg_data[DEPTH_WIDTH-1:0];
                    REG_FIRST_ID: next_id_q = i_cfg_data[ID_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (push && !full) subdivide_triangle(i_tri);
            if (pop && !empty) begin
                if (expected_beats.size() == 0) begin
                    if (mismatches + stray_beats < 10)
                        $display("ctsd_checker: unexpected beat %s", beat_text(i_res));
                    stray_beats++;
                end else begin
                    want = expected_beats.pop_front();
                    if (i_res.kind !== want.kind || i_res.vertex_a !== want.vertex_a ||
                        i_res.vertex_b !== want.vertex_b ||
                        i_res.vertex_c !== want.vertex_c ||
                        i_res.point_x !== want.point_x || i_res.point_y !== want.point_y ||
                        i_res.point_z !== want.point_z ||
                        i_res.id_overflow !== want.id_overflow ||
                        i_res.last !== want.last) begin
                        if (mismatches + stray_beats < 10) begin
                            $display("ctsd_checker: mismatch at %0t", $realtime);
                            $display("  expected %s", beat_text(want));
                            $display("  actual   %s", beat_text(i_res));
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_errors  <= mismatches + stray_beats;
        o_pending <= expected_beats.size();
        o_points  <= point_count;
        o_tris    <= tri_count;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for centroid_triangle_subdivider_unit
// Drives triangles and register writes, pops results with random stalls and
// leaves checking to ctsd_checker. Directed extremes (zero, max and min
// coordinates, truncation of negative sums, depth 0 pass-through, id counter
// saturation) are followed by random phases over all depths and start ids.
// ----------------------------------------------------------------------------
module tb_top;
    import ctsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 26;

    logic                      i_clk    = 1'b0;
    logic                      i_rst_n  = 1'b0;
    logic                      push     = 1'b0;
    logic                      full;
    t_tri_in                   tri_beat = '0;
    logic                      empty;
    logic                      pop      = 1'b0;
    t_result                   res_beat;
    logic                      cfg_we   = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

    int errors;
    int pending;
    int points_seen;
    int tris_seen;
    int tris_sent;
    int idle_cycles;
    int pop_stall;
    bit calm;

    always #5 i_clk = ~i_clk;

    centroid_triangle_subdivider_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_tri      (tri_beat),
        .empty      (empty),
        .pop        (pop),
        .o_res      (res_beat),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ctsd_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_tri      (tri_beat),
        .empty      (empty),
        .pop        (pop),
        .i_res      (res_beat),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_points   (points_seen),
        .o_tris     (tris_seen)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop       <= 1'b0;
            pop_stall = 0;
        end else if (pop_stall > 0) begin
            pop       <= 1'b0;
            pop_stall--;
        end else if (calm || $urandom_range(0, 3) != 0) begin
            pop <= 1'b1;
        end else begin
            pop       <= 1'b0;
            pop_stall = $urandom_range(0, 4);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        push <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_depth(input int depth);
        logic [CFG_DATA_WIDTH-1:0] data;
        data                  = $urandom();
        data[DEPTH_WIDTH-1:0] = depth[DEPTH_WIDTH-1:0];
        write_reg(REG_DEPTH, data);
    endtask

    task automatic send_tri(input t_tri_in t);
        if (!calm && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        push     <= 1'b1;
        tri_beat <= t;
        do @(posedge i_clk); while (full);
        tris_sent++;
    endtask

    function automatic t_tri_in corner_tri(
        input logic [ID_WIDTH-1:0] id0, id1, id2,
        input logic [COORD_WIDTH-1:0] v0, v1, v2
    );
        t_tri_in t;
        t.corner0_id = id0;
        t.corner1_id = id1;
        t.corner2_id = id2;
        t.corner0_x = v0;
        t.corner0_y = v0;
        t.corner0_z = ~v0;
        t.corner1_x = v1;
        t.corner1_y = v1;
        t.corner1_z = ~v1;
        t.corner2_x = v2;
        t.corner2_y = v2;
        t.corner2_z = ~v2;
        return t;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        logic [COORD_WIDTH-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'h7fff_ffff;
            1:       v = 32'h8000_0000;
            2:       v = $signed($urandom_range(0, 131072)) - 65536;
            3:       v = $signed($urandom()) >>> $urandom_range(1, 20);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic t_tri_in rand_tri();
        t_tri_in t;
        t.corner0_id = $urandom();
        t.corner1_id = $urandom();
        t.corner2_id = $urandom();
        t.corner0_x  = rand_coord();
        t.corner0_y  = rand_coord();
        t.corner0_z  = rand_coord();
        t.corner1_x  = rand_coord();
        t.corner1_y  = rand_coord();
        t.corner1_z  = rand_coord();
        t.corner2_x  = rand_coord();
        t.corner2_y  = rand_coord();
        t.corner2_z  = rand_coord();
        return t;
    endfunction

    function automatic logic [ID_WIDTH-1:0] pick_first_id();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            3:       return 32'hffff_ffff - $urandom_range(0, 20);
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    initial begin
        tris_sent = 0;
        calm      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: depth 1, ids from zero
        send_tri(corner_tri(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        send_tri(corner_tri('1, '1, '1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_tri(corner_tri(32'd1, 32'd2, 32'd3,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_tri(corner_tri(32'd4, 32'd5, 32'd6, 32'd1, 32'd1, 32'd0));
        send_tri(corner_tri(32'd7, 32'd8, 32'd9, -32'sd1, -32'sd1, 32'd0));
        send_tri(corner_tri(32'd10, 32'd11, 32'd12, -32'sd4, 32'd0, 32'd0));
        send_tri(corner_tri(32'haaaa_aaaa, 32'h5555_5555, 32'h0f0f_0f0f,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        send_tri(corner_tri(32'h5555_5555, 32'haaaa_aaaa, 32'hf0f0_f0f0,
                            32'haaaa_aaaa, 32'h5555_5555, 32'h8000_0001));

        set_depth(0);
        send_tri(corner_tri('1, 32'd0, '1, 32'h8000_0000, 32'h7fff_ffff, 32'd0));
        send_tri(rand_tri());

        // counter runs into saturation partway through a depth 3 tree
        set_depth(3);
        write_reg(REG_FIRST_ID, 32'hffff_fff8);
        send_tri(rand_tri());
        send_tri(rand_tri());

        set_depth(2);
        write_reg(REG_FIRST_ID, 32'hffff_ffff);
        send_tri(rand_tri());

        set_depth(3);
        write_reg(REG_FIRST_ID, 32'd0);
        send_tri(corner_tri(32'd0, '1, 32'd0,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_depth((ph == RAND_PHASES - 1) ? MAX_DEPTH : $urandom_range(0, 3));
            if (ph % 2 == 0 || ph == RAND_PHASES - 1)
                write_reg(REG_FIRST_ID, pick_first_id());
            if (ph >= RAND_PHASES - 2) calm = 1'b1;
            repeat (PHASE_ITEMS) send_tri(rand_tri());
        end

        push <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d triangles in, %0d points and %0d leaf triangles checked",
                 tris_sent, points_seen, tris_seen);
        $display("tb_top: depths 0 to 3, id saturation, random stalls on both sides");
        if (errors == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/ctsd_pkg.sv
design/ctsd_front.sv
design/ctsd_centroid.sv
design/ctsd_back.sv
design/centroid_triangle_subdivider_unit.sv
design/ctsd_checker.sv
tb/ctsd_checker.sv
tb/tb_top.sv
